>>> hw/rtl/gdn_pkg.sv
`timescale 1ns / 1ps

package gdn_pkg;

    // Field widths
    localparam int DATA_W = 32;
    localparam int DIV_W  = 36;
    localparam int ROW_W  = 16;
    localparam int OCOL_W = 10;
    localparam int IMW_W  = 11;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [IMW_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [ROW_W-1:0] IMAGE_HEIGHT_RST = 16'd1024;

    // Position flags of one pixel in the input register
    typedef struct packed {
        logic has_up;    // row >= 1, the pixel above is finished
        logic top;       // the pixel above sits on the first row
        logic last_row;
        logic c0;
        logic c1;
        logic c_last;
    } pix_flags_t;

    // One finished divergence pixel
    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [OCOL_W-1:0]       col;
        logic signed [DIV_W-1:0] f;
    } res_t;

    // Sign-extend a gradient sample to the result width
    function automatic logic signed [DIV_W-1:0] sx(input logic [DATA_W-1:0] v);
        sx = {{(DIV_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

endpackage

>>> hw/rtl/gradient_divergence_neumann_edges.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// pix       in         pix_valid/pix_stall   grad_x, grad_y
// res       out        res_valid/res_stall   out_row, out_col, divergence, run_last
// apb       in         psel/penable/pready   paddr, pwdata, prdata
//
// One pixel per cycle enters the input register while pix_stall is low; its results
// go to the result register. A last-row pixel gives two results (one at column 0,
// three at the final pixel); the single result register sends one per cycle while
// res_stall is low, so on that row the input register takes a new pixel only as
// the result register sends its last result. Reset zeroes the position counters
// and sets width and height to 1024; the line stores are not cleared. res_stall
// holds the result register; pix_stall rises when the input register cannot drain.

module gradient_divergence_neumann_edges
    import gdn_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    // gradient pixels
    input  logic                     pix_valid,
    output logic                     pix_stall,
    input  logic [DATA_W-1:0]        grad_x,
    input  logic [DATA_W-1:0]        grad_y,
    // divergence results
    output logic                     res_valid,
    input  logic                     res_stall,
    output logic [ROW_W-1:0]         out_row,
    output logic [OCOL_W-1:0]        out_col,
    output logic signed [DIV_W-1:0]  divergence,
    output logic                     run_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int GX_D  = 2 * MAX_WIDTH;
    localparam int GY_D  = 3 * MAX_WIDTH;
    localparam int AWX   = $clog2(GX_D);
    localparam int AWY   = $clog2(GY_D);

    // Configuration registers
    logic [IMW_W-1:0] image_width_reg;
    logic [ROW_W-1:0] image_height_reg;
    logic             cfg_wr;

    // Position counters
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [1:0]       ph_reg, ph_next;

    logic [CW-1:0]    last_col;
    logic [ROW_W-1:0] last_row;
    logic [31:0]      wreq;
    logic             restart;
    logic [ROW_W-1:0] row_eff;
    logic [CW-1:0]    col_eff;
    logic [1:0]       ph_eff;
    logic [1:0]       up1_slot, up2_slot;
    logic [CW-1:0]    col_right;
    pix_flags_t       flags_in;

    // Input register
    logic             s1_valid_reg, s1_valid_next;
    logic [ROW_W-1:0] s1_row_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [DATA_W-1:0] s1_gx_reg, s1_gy_reg;
    pix_flags_t       s1_flags_reg;

    // Neighbors kept from the previous pixel
    logic [DATA_W-1:0] h_gxb_reg, h_gx_reg, h_gx2_reg, h_gy_reg, h_gy1_reg;

    // Line store ports
    logic [AWX-1:0]    gx_waddr, gx_raddr_a, gx_raddr_b, gx_base_up;
    logic [AWY-1:0]    gy_waddr, gy_raddr_a, gy_raddr_b;
    logic [DATA_W-1:0] gx_right, gx_mid, gy_up1, gy_up2;

    // Result register
    logic             s2_valid_reg, s2_valid_next;
    logic [1:0]       s2_cnt_reg, s2_cnt_next;
    logic [1:0]       s2_idx_reg, s2_idx_next;
    res_t             s2_res_reg [3];
    res_t             res_next [3];
    res_t             res_sel;
    logic [1:0]       n_res;

    logic pix_accept, res_xfer, s2_last, s1_adv;

    logic signed [DIV_W-1:0] left1, up1, corr1, f1;
    logic signed [DIV_W-1:0] left2, corr2, f2;
    logic signed [DIV_W-1:0] corr3, f3;
    logic [ROW_W-1:0]        row_m1;
    logic [CW-1:0]           col_m1;

    function automatic logic [AWY-1:0] gy_base(input logic [1:0] slot);
        case (slot)
            2'd0:    gy_base = '0;
            2'd1:    gy_base = AWY'(MAX_WIDTH);
            default: gy_base = AWY'(2 * MAX_WIDTH);
        endcase
    endfunction

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[REG_SEL_BIT])
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[IMW_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[REG_SEL_BIT])
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // Clamp the image size in use
    //------------------------------------------------------------------
    assign wreq = 32'(image_width_reg);

    always_comb
    begin
        if (wreq < 32'd3)
            last_col = CW'(2);
        else if (wreq > 32'(MAX_WIDTH))
            last_col = CW'(MAX_WIDTH - 1);
        else
            last_col = CW'(wreq - 32'd1);

        if (image_height_reg < 16'd3)
            last_row = 16'd2;
        else
            last_row = image_height_reg - 16'd1;
    end

    //------------------------------------------------------------------
    // Position of the incoming pixel and line store addresses
    //------------------------------------------------------------------
    always_comb
    begin
        restart = (col_reg > last_col) || (row_reg > last_row);
        row_eff = restart ? '0 : row_reg;
        col_eff = restart ? '0 : col_reg;
        ph_eff  = restart ? 2'd0 : ph_reg;

        up1_slot = (ph_eff == 2'd0) ? 2'd2 : ph_eff - 2'd1;
        up2_slot = (ph_eff == 2'd2) ? 2'd0 : ph_eff + 2'd1;

        // right neighbor clamps to the pixel itself on the last column
        col_right = (col_eff == last_col) ? col_eff : col_eff + CW'(1);

        gx_base_up = row_eff[0] ? '0 : AWX'(MAX_WIDTH);
        gx_waddr   = (row_eff[0] ? AWX'(MAX_WIDTH) : '0) + AWX'(col_eff);
        gx_raddr_a = gx_base_up + AWX'(col_right);
        gx_raddr_b = gx_base_up + AWX'(col_eff);

        gy_waddr   = gy_base(ph_eff) + AWY'(col_eff);
        gy_raddr_a = gy_base(up1_slot) + AWY'(col_eff);
        gy_raddr_b = gy_base(up2_slot) + AWY'(col_eff);

        flags_in.has_up   = (row_eff != '0);
        flags_in.top      = (row_eff == 16'd1);
        flags_in.last_row = (row_eff == last_row);
        flags_in.c0       = (col_eff == '0);
        flags_in.c1       = (col_eff == CW'(1));
        flags_in.c_last   = (col_eff == last_col);
    end

    // Advance the counters on each input transfer; a configuration write zeroes them and wins
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        ph_next  = ph_reg;
        if (cfg_wr)
        begin
            row_next = '0;
            col_next = '0;
            ph_next  = 2'd0;
        end
        else if (pix_accept)
        begin
            if (col_eff == last_col)
            begin
                col_next = '0;
                if (row_eff == last_row)
                begin
                    row_next = '0;
                    ph_next  = 2'd0;
                end
                else
                begin
                    row_next = row_eff + 16'd1;
                    ph_next  = (ph_eff == 2'd2) ? 2'd0 : ph_eff + 2'd1;
                end
            end
            else
            begin
                col_next = col_eff + CW'(1);
                row_next = row_eff;
                ph_next  = ph_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            ph_reg  <= 2'd0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            ph_reg  <= ph_next;
        end
    end

    //------------------------------------------------------------------
    // Line stores: two rows of grad_x, three rows of grad_y
    //------------------------------------------------------------------
    gdn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (GX_D)
    ) u_gx_ram (
        .clk     (clk),
        .we      (pix_accept),
        .waddr   (gx_waddr),
        .wdata   (grad_x),
        .re      (pix_accept),
        .raddr_a (gx_raddr_a),
        .raddr_b (gx_raddr_b),
        .rdata_a (gx_right),
        .rdata_b (gx_mid)
    );

    gdn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (GY_D)
    ) u_gy_ram (
        .clk     (clk),
        .we      (pix_accept),
        .waddr   (gy_waddr),
        .wdata   (grad_y),
        .re      (pix_accept),
        .raddr_a (gy_raddr_a),
        .raddr_b (gy_raddr_b),
        .rdata_a (gy_up1),
        .rdata_b (gy_up2)
    );

    //------------------------------------------------------------------
    // Handshakes
    //------------------------------------------------------------------
    assign res_xfer   = s2_valid_reg && !res_stall;
    assign s2_last    = (s2_idx_reg == s2_cnt_reg - 2'd1);
    assign s1_adv     = s1_valid_reg && (!s2_valid_reg || (res_xfer && s2_last));
    assign pix_stall  = s1_valid_reg && !s1_adv;
    assign pix_accept = pix_valid && !pix_stall;

    // Load the input register
    assign s1_valid_next = pix_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_row_reg   <= row_eff;
            s1_col_reg   <= col_eff;
            s1_gx_reg    <= grad_x;
            s1_gy_reg    <= grad_y;
            s1_flags_reg <= flags_in;
        end
        // keep this pixel's samples as the left neighbors of the next one
        if (s1_adv)
        begin
            h_gxb_reg <= gx_mid;
            h_gx_reg  <= s1_gx_reg;
            h_gx2_reg <= h_gx_reg;
            h_gy_reg  <= s1_gy_reg;
            h_gy1_reg <= gy_up1;
        end
    end

    //------------------------------------------------------------------
    // Divergence of the up to three finished pixels
    //------------------------------------------------------------------
    always_comb
    begin
        // pixel above the current one
        left1 = s1_flags_reg.c0 ? sx(gx_mid) : sx(h_gxb_reg);
        up1   = s1_flags_reg.top ? sx(gy_up1) : sx(gy_up2);
        corr1 = (s1_flags_reg.top ? sx(gy_up1) : '0)
              + (s1_flags_reg.c0 ? sx(gx_mid) : '0)
              - (s1_flags_reg.c_last ? sx(gx_mid) : '0);
        f1 = sx(gx_right) - left1 + sx(s1_gy_reg) - up1
           + {corr1[DIV_W-2:0], 1'b0};

        // left neighbor on the last row
        left2 = s1_flags_reg.c1 ? sx(h_gx_reg) : sx(h_gx2_reg);
        corr2 = (s1_flags_reg.c1 ? sx(h_gx_reg) : '0) - sx(h_gy_reg);
        f2 = sx(s1_gx_reg) - left2 + sx(h_gy_reg) - sx(h_gy1_reg)
           + {corr2[DIV_W-2:0], 1'b0};

        // bottom-right corner
        corr3 = -sx(s1_gy_reg) - sx(s1_gx_reg);
        f3 = sx(s1_gx_reg) - sx(h_gx_reg) + sx(s1_gy_reg) - sx(gy_up1)
           + {corr3[DIV_W-2:0], 1'b0};

        row_m1 = s1_row_reg - 16'd1;
        col_m1 = s1_col_reg - CW'(1);

        res_next[0].row = row_m1;
        res_next[0].col = OCOL_W'((CW + OCOL_W)'(s1_col_reg));
        res_next[0].f   = f1;
        res_next[1].row = s1_row_reg;
        res_next[1].col = OCOL_W'((CW + OCOL_W)'(col_m1));
        res_next[1].f   = f2;
        res_next[2].row = s1_row_reg;
        res_next[2].col = OCOL_W'((CW + OCOL_W)'(s1_col_reg));
        res_next[2].f   = f3;

        if (!s1_flags_reg.has_up)
            n_res = 2'd0;
        else if (!s1_flags_reg.last_row || s1_flags_reg.c0)
            n_res = 2'd1;
        else if (s1_flags_reg.c_last)
            n_res = 2'd3;
        else
            n_res = 2'd2;
    end

    //------------------------------------------------------------------
    // Result register: send the results one transfer at a time
    //------------------------------------------------------------------
    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s2_cnt_next   = s2_cnt_reg;
        s2_idx_next   = s2_idx_reg;
        if (s1_adv)
        begin
            s2_valid_next = (n_res != 2'd0);
            s2_cnt_next   = n_res;
            s2_idx_next   = 2'd0;
        end
        else if (res_xfer)
        begin
            if (s2_last)
                s2_valid_next = 1'b0;
            else
                s2_idx_next = s2_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_cnt_reg   <= 2'd0;
            s2_idx_reg   <= 2'd0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s2_cnt_reg   <= s2_cnt_next;
            s2_idx_reg   <= s2_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_res_reg[0] <= res_next[0];
            s2_res_reg[1] <= res_next[1];
            s2_res_reg[2] <= res_next[2];
        end
    end

    always_comb
    begin
        case (s2_idx_reg)
            2'd0:    res_sel = s2_res_reg[0];
            2'd1:    res_sel = s2_res_reg[1];
            default: res_sel = s2_res_reg[2];
        endcase
    end

    assign res_valid  = s2_valid_reg;
    assign out_row    = res_sel.row;
    assign out_col    = res_sel.col;
    assign divergence = res_sel.f;
    assign run_last   = s2_last;

    //------------------------------------------------------------------
    // Checks
    //------------------------------------------------------------------
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_idx_reg < s2_cnt_reg))
        else $error("result index beyond result count");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !run_last) |=> res_valid)
        else $error("results of one pixel broken up");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= last_col)
        else $error("column counter beyond image width");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && res_stall) |-> !pix_accept)
        else $error("pixel taken while both registers are held");

endmodule

>>> hw/rtl/gdn_ram.sv
`timescale 1ns / 1ps

module gdn_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read two with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule
